// ===== hdl/dfsa_pkg.sv =====
// package for the dual free list slab allocator
// holds defaults, status and command codes and the control state type
// no dependencies
package dfsa_pkg;

  localparam int ADDR_W   = 48;
  localparam int REQ_W    = 20;
  localparam int STATUS_W = 3;

  localparam int SLAB_BYTES_DEF = 1024;
  localparam int SLAB_COUNT_DEF = 256;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED    = 3'd0,
    STAT_OVERSIZE   = 3'd1,
    STAT_EMPTY      = 3'd2,
    STAT_OWNER_PUSH = 3'd3,
    STAT_OTHER_PUSH = 3'd4,
    STAT_FOREIGN    = 3'd5,
    STAT_OVERFLOW   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCALE,
    S_PUSH,
    S_OUT
  } state_t;

endpackage

// ===== hdl/dfsa_in_if.sv =====
// request channel of the slab allocator
// depends on dfsa_pkg for field widths
interface dfsa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [dfsa_pkg::REQ_W-1:0]    request_bytes;
  logic [dfsa_pkg::ADDR_W-1:0]   block_address;
  logic                          from_owner;

  modport source (output valid, command, request_bytes, block_address, from_owner,
                  input ready);
  modport sink (input valid, command, request_bytes, block_address, from_owner,
                output ready);
endinterface

// ===== hdl/dfsa_out_if.sv =====
// result channel of the slab allocator
// depends on dfsa_pkg for field widths
interface dfsa_out_if;
  logic                            valid;
  logic                            ready;
  logic [dfsa_pkg::STATUS_W-1:0]   status;
  logic [dfsa_pkg::ADDR_W-1:0]     slab_address;
  logic                            lists_swapped;

  modport source (output valid, status, slab_address, lists_swapped, input ready);
  modport sink (input valid, status, slab_address, lists_swapped, output ready);
endinterface

// ===== hdl/dfsa_cfg_if.sv =====
// configuration write channel of the slab allocator, pool base address
// depends on dfsa_pkg for the address width
interface dfsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dfsa_pkg::ADDR_W-1:0]   pool_base;

  modport source (output valid, pool_base, input ready);
  modport sink (input valid, pool_base, output ready);
endinterface

// ===== hdl/dual_free_list_slab_allocator_unit.sv =====
// Slab allocator with two LIFO free lists held in two synchronous memories of
// SLAB_COUNT slab indices each. One request is handled at a time. An allocate
// passes through decode with the memory read, address build and hand-off to
// the output register before the next acceptance; a free passes through range
// check, reciprocal multiply that turns the pool offset into a slab index,
// push and hand-off. Oversize, empty and foreign requests go from decode
// straight to hand-off. A new request is taken while a result still waits
// in the output register. No clearing pass follows reset: untouched entries
// of the first bank read as their own index through a low watermark.
// Write pool_base only while no request is in flight.
// depends on dfsa_pkg and the dfsa_in_if, dfsa_out_if and dfsa_cfg_if interfaces
module dual_free_list_slab_allocator_unit #(
  parameter int SLAB_BYTES = dfsa_pkg::SLAB_BYTES_DEF,
  parameter int SLAB_COUNT = dfsa_pkg::SLAB_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dfsa_in_if.sink    in_ch,
  dfsa_out_if.source out_ch,
  dfsa_cfg_if.sink   cfg_ch
);

  localparam int ADDR_W   = dfsa_pkg::ADDR_W;
  localparam int REQ_W    = dfsa_pkg::REQ_W;
  localparam int IDX_W    = $clog2(SLAB_COUNT);
  localparam int CNT_W    = $clog2(SLAB_COUNT + 1);
  localparam int BYTE_W   = $clog2(SLAB_BYTES);
  localparam int OFF_W    = $clog2(SLAB_COUNT * SLAB_BYTES);
  localparam int SH       = OFF_W + BYTE_W;
  localparam int RECIP_W  = OFF_W + 1;
  localparam int PROD_W   = OFF_W + RECIP_W;
  localparam int SCALE_W  = IDX_W + BYTE_W + 1;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(SLAB_BYTES) - 64'd1) /
                                       64'(SLAB_BYTES);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_FULL[RECIP_W-1:0];
  localparam logic [ADDR_W:0]    SPAN      = (ADDR_W+1)'(SLAB_COUNT * SLAB_BYTES);
  localparam logic [REQ_W:0]     REQ_LIMIT = (REQ_W+1)'(SLAB_BYTES);
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(SLAB_COUNT);
  localparam logic [BYTE_W:0]    SLAB_SIZE = (BYTE_W+1)'(SLAB_BYTES);

  dfsa_pkg::state_t  state_r, state_nxt;

  logic               cmd_r, cmd_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [ADDR_W-1:0]  baddr_r, baddr_nxt;
  logic               from_owner_r, from_owner_nxt;
  logic [ADDR_W-1:0]  pool_base_r;

  logic [CNT_W-1:0]   cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]   cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]   lw_a_r, lw_a_nxt;
  logic               own_b_r, own_b_nxt;

  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               rd_fixed_r, rd_fixed_nxt;
  logic               rd_bank_r, rd_bank_nxt;

  dfsa_pkg::status_t  res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic               res_swap_r, res_swap_nxt;

  logic               out_valid_r, out_valid_nxt;
  dfsa_pkg::status_t  out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic               out_swap_r, out_swap_nxt;

  logic [IDX_W-1:0]   bank_a_mem [SLAB_COUNT];
  logic [IDX_W-1:0]   bank_b_mem [SLAB_COUNT];
  logic [IDX_W-1:0]   rd_a_r, rd_b_r;
  logic               we_a, we_b, re_a, re_b;
  logic [IDX_W-1:0]   waddr, raddr, wdata;

  logic               in_fire;
  logic               out_free;
  logic [ADDR_W:0]    diff;
  logic [PROD_W-1:0]  recip_prod;
  logic [IDX_W-1:0]   pop_idx;
  logic [SCALE_W-1:0] scaled;
  logic               swap;
  logic               pop_bank;
  logic               push_bank;
  logic [CNT_W-1:0]   cnt_own, cnt_oth, cnt_pop, top, cnt_push;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == dfsa_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slab_address  = out_addr_r;
  assign out_ch.lists_swapped = out_swap_r;

  assign diff       = {1'b0, baddr_r} - {1'b0, pool_base_r};
  assign recip_prod = PROD_W'(off_r) * PROD_W'(RECIP);
  assign pop_idx    = rd_fixed_r ? rd_idx_r : (rd_bank_r ? rd_b_r : rd_a_r);
  assign scaled     = SCALE_W'(pop_idx) * SCALE_W'(SLAB_SIZE);

  assign cnt_own   = own_b_r ? cnt_b_r : cnt_a_r;
  assign cnt_oth   = own_b_r ? cnt_a_r : cnt_b_r;
  assign swap      = (cnt_own == '0);
  assign pop_bank  = own_b_r ^ swap;
  assign cnt_pop   = pop_bank ? cnt_b_r : cnt_a_r;
  assign top       = cnt_pop - CNT_W'(1);
  assign push_bank = own_b_r ^ !from_owner_r;
  assign cnt_push  = push_bank ? cnt_b_r : cnt_a_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    baddr_nxt      = baddr_r;
    from_owner_nxt = from_owner_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    lw_a_nxt       = lw_a_r;
    own_b_nxt      = own_b_r;
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    rd_fixed_nxt   = rd_fixed_r;
    rd_bank_nxt    = rd_bank_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_swap_nxt   = res_swap_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_swap_nxt   = out_swap_r;
    we_a           = 1'b0;
    we_b           = 1'b0;
    re_a           = 1'b0;
    re_b           = 1'b0;
    waddr          = cnt_push[IDX_W-1:0];
    wdata          = idx_r;
    raddr          = top[IDX_W-1:0];

    unique case (state_r)
      dfsa_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_ch.command;
          req_nxt        = in_ch.request_bytes;
          baddr_nxt      = in_ch.block_address;
          from_owner_nxt = in_ch.from_owner;
          state_nxt      = dfsa_pkg::S_EXEC;
        end
      end
      dfsa_pkg::S_EXEC: begin
        res_addr_nxt = '0;
        res_swap_nxt = 1'b0;
        if (cmd_r == dfsa_pkg::CMD_ALLOC) begin
          if ({1'b0, req_r} > REQ_LIMIT) begin
            res_status_nxt = dfsa_pkg::STAT_OVERSIZE;
            state_nxt      = dfsa_pkg::S_OUT;
          end else if (swap && (cnt_oth == '0)) begin
            res_status_nxt = dfsa_pkg::STAT_EMPTY;
            state_nxt      = dfsa_pkg::S_OUT;
          end else begin
            re_a         = !pop_bank;
            re_b         = pop_bank;
            rd_bank_nxt  = pop_bank;
            rd_idx_nxt   = top[IDX_W-1:0];
            rd_fixed_nxt = !pop_bank && (top < lw_a_r);
            own_b_nxt    = pop_bank;
            res_swap_nxt = swap;
            if (pop_bank) begin
              cnt_b_nxt = top;
            end else begin
              cnt_a_nxt = top;
            end
            state_nxt = dfsa_pkg::S_READ;
          end
        end else begin
          if (diff[ADDR_W] || (diff >= SPAN)) begin
            res_status_nxt = dfsa_pkg::STAT_FOREIGN;
            state_nxt      = dfsa_pkg::S_OUT;
          end else begin
            off_nxt   = diff[OFF_W-1:0];
            state_nxt = dfsa_pkg::S_SCALE;
          end
        end
      end
      dfsa_pkg::S_READ: begin
        res_status_nxt = dfsa_pkg::STAT_GRANTED;
        res_addr_nxt   = pool_base_r + ADDR_W'(scaled);
        state_nxt      = dfsa_pkg::S_OUT;
      end
      dfsa_pkg::S_SCALE: begin
        idx_nxt   = recip_prod[SH +: IDX_W];
        state_nxt = dfsa_pkg::S_PUSH;
      end
      dfsa_pkg::S_PUSH: begin
        if (cnt_push == CNT_FULL) begin
          res_status_nxt = dfsa_pkg::STAT_OVERFLOW;
        end else begin
          we_a = !push_bank;
          we_b = push_bank;
          res_status_nxt = from_owner_r ? dfsa_pkg::STAT_OWNER_PUSH
                                        : dfsa_pkg::STAT_OTHER_PUSH;
          if (push_bank) begin
            cnt_b_nxt = cnt_push + CNT_W'(1);
          end else begin
            cnt_a_nxt = cnt_push + CNT_W'(1);
            if (cnt_push < lw_a_r) begin
              lw_a_nxt = cnt_push;
            end
          end
        end
        state_nxt = dfsa_pkg::S_OUT;
      end
      dfsa_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_swap_nxt   = res_swap_r;
          state_nxt      = dfsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dfsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfsa_pkg::S_IDLE;
      pool_base_r <= '0;
      cnt_a_r     <= CNT_FULL;
      cnt_b_r     <= '0;
      lw_a_r      <= CNT_FULL;
      own_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      lw_a_r      <= lw_a_nxt;
      own_b_r     <= own_b_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        pool_base_r <= cfg_ch.pool_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    baddr_r      <= baddr_nxt;
    from_owner_r <= from_owner_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_fixed_r   <= rd_fixed_nxt;
    rd_bank_r    <= rd_bank_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_swap_r   <= res_swap_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_swap_r   <= out_swap_nxt;
  end

  // bank a
  always_ff @(posedge clk) begin
    if (we_a) begin
      bank_a_mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_r <= bank_a_mem[raddr];
    end
  end

  // bank b
  always_ff @(posedge clk) begin
    if (we_b) begin
      bank_b_mem[waddr] <= wdata;
    end
    if (re_b) begin
      rd_b_r <= bank_b_mem[raddr];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_FULL) && (cnt_b_r <= CNT_FULL))
    else $error("free list count beyond pool size");

  a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfsa_pkg::S_READ) |-> ($past(state_r) == dfsa_pkg::S_EXEC) && $past(re_a || re_b))
    else $error("pop result used without a memory read");

  a_swap_only_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfsa_pkg::S_OUT && res_swap_r) |-> (res_status_r == dfsa_pkg::STAT_GRANTED))
    else $error("list swap reported without a grant");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == dfsa_pkg::S_EXEC))
    else $error("accepted transaction not processed");

  a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_a && we_b) && !((we_a || we_b) && (re_a || re_b)))
    else $error("conflicting memory accesses");
`endif

endmodule
